FILE: rtl/mmd_pkg.sv
`default_nettype none

package mmd_pkg;

  localparam int unsigned MAX_CHANNELS = 64;
  localparam int unsigned SAMPLE_WIDTH = 32;

  // field and register widths
  localparam int unsigned CH_W      = 6;
  localparam int unsigned NCH_W     = 7;
  localparam int unsigned STEP_W    = 16;
  localparam int unsigned FAC_W     = 17;
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ADDR_W    = $clog2(MAX_CHANNELS);

  localparam int unsigned FACTOR_LIMIT = 65536;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [CH_W-1:0]                chan_t;
  typedef logic [CFG_W-1:0]               cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_CHANNELS = 2'd0,
    REG_DECIM_FACTOR = 2'd1,
    REG_SINGLE_PLANE = 2'd2
  } reg_idx_e;

  // position of the current request within the frame and the group
  typedef struct packed {
    chan_t ch;
    logic  first;
    logic  ch_last;
    logic  step_last;
  } seq_t;

endpackage

`default_nettype wire

FILE: rtl/mmd_sample_if.sv
`default_nettype none

interface mmd_sample_if;
  import mmd_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_low;
  sample_t sample_high;

  modport source (output valid, output sample_low, output sample_high, input ready);
  modport sink (input valid, input sample_low, input sample_high, output ready);
endinterface

`default_nettype wire

FILE: rtl/mmd_result_if.sv
`default_nettype none

interface mmd_result_if;
  import mmd_pkg::*;

  logic    valid;
  logic    ready;
  chan_t   channel;
  sample_t min_value;
  sample_t max_value;
  logic    group_last;

  modport source (
    output valid, output channel, output min_value, output max_value, output group_last,
    input ready
  );
  modport sink (
    input valid, input channel, input min_value, input max_value, input group_last,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/mmd_seq.sv
`default_nettype none

module mmd_seq (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [mmd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire mmd_pkg::cfg_data_t               cfg_data_i,
  input  wire logic                             advance_i,
  output mmd_pkg::seq_t                         seq_o,
  output logic                                  single_plane_o
);
  import mmd_pkg::*;

  logic [NCH_W-1:0]  num_ch_q;
  logic [FAC_W-1:0]  fac_q;
  logic              single_q;
  chan_t             ch_q, ch_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic [NCH_W-1:0]  nc;
  logic [FAC_W-1:0]  fac;
  logic              ch_last;
  logic              step_last;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ch_q <= NCH_W'(1);
      fac_q    <= FAC_W'(4);
      single_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_NUM_CHANNELS: num_ch_q <= cfg_data_i[NCH_W-1:0];
        REG_DECIM_FACTOR: fac_q    <= cfg_data_i[FAC_W-1:0];
        REG_SINGLE_PLANE: single_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamp out-of-range settings
  always_comb begin
    if (num_ch_q == '0) begin
      nc = NCH_W'(1);
    end else if (num_ch_q > NCH_W'(MAX_CHANNELS)) begin
      nc = NCH_W'(MAX_CHANNELS);
    end else begin
      nc = num_ch_q;
    end
    if (fac_q == '0) begin
      fac = FAC_W'(1);
    end else if (fac_q > FAC_W'(FACTOR_LIMIT)) begin
      fac = FAC_W'(FACTOR_LIMIT);
    end else begin
      fac = fac_q;
    end
  end

  assign ch_last   = (NCH_W'(ch_q) + NCH_W'(1)) >= nc;
  assign step_last = (FAC_W'(step_q) + FAC_W'(1)) >= fac;

  always_comb begin
    ch_d   = ch_q;
    step_d = step_q;
    if (advance_i) begin
      if (ch_last) begin
        ch_d   = '0;
        step_d = step_last ? '0 : step_q + STEP_W'(1);
      end else begin
        ch_d = ch_q + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q   <= '0;
      step_q <= '0;
    end else begin
      ch_q   <= ch_d;
      step_q <= step_d;
    end
  end

  assign seq_o.ch        = ch_q;
  assign seq_o.first     = (step_q == '0);
  assign seq_o.ch_last   = ch_last;
  assign seq_o.step_last = step_last;
  assign single_plane_o  = single_q;

endmodule

`default_nettype wire

FILE: rtl/multichannel_minmax_decimator.sv
`default_nettype none

// channel     dir  payload                                       notes
// sample_i    in   sample_low, sample_high                       interleaved by channel
// result_o    out  channel, min_value, max_value, group_last     one per channel per group
// cfg port    in   cfg_we_i, cfg_idx_i, cfg_data_i               write only, change when idle
//
// one request per cycle unless stalled; a result passes stage 1 and the result register
// pipeline: request -> stage 1 (min/max memory read data, registered) -> result register
// the min/max memories take one read and one write per cycle; a back-to-back request
// to the same channel gets the stage 1 value forwarded instead of the memory word
// reset clears the counters, config and valid flags only; the memories need no clearing
// a stalled result register holds stage 1, which then holds the input side

module multichannel_minmax_decimator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  mmd_sample_if.sink                         sample_i,
  mmd_result_if.source                       result_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mmd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire mmd_pkg::cfg_data_t            cfg_data_i
);
  import mmd_pkg::*;

  // per-channel running extremes
  sample_t min_mem [MAX_CHANNELS];
  sample_t max_mem [MAX_CHANNELS];

  seq_t    seq;
  logic    single_plane;
  logic    accept;

  // stage 1
  logic    s1_valid_q;
  seq_t    s1_seq_q;
  sample_t s1_lo_q, s1_hi_q;
  sample_t rd_min_q, rd_max_q;
  logic    fwd_q;
  sample_t fwd_min_q, fwd_max_q;
  logic    s1_adv;
  sample_t old_min, old_max;
  sample_t new_min, new_max;

  // result register
  logic    out_valid_q;
  chan_t   out_ch_q;
  sample_t out_min_q, out_max_q;
  logic    out_last_q;

  mmd_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .advance_i      (accept),
    .seq_o          (seq),
    .single_plane_o (single_plane)
  );

  // stage 1 moves on when the result register is free or draining
  assign s1_adv         = s1_valid_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready = !s1_valid_q || s1_adv;
  assign accept         = sample_i.valid && sample_i.ready;

  // min over lows, max over highs; first step of a group starts fresh
  always_comb begin
    old_min = fwd_q ? fwd_min_q : rd_min_q;
    old_max = fwd_q ? fwd_max_q : rd_max_q;
    if (s1_seq_q.first) begin
      new_min = s1_lo_q;
      new_max = s1_hi_q;
    end else begin
      new_min = (s1_lo_q < old_min) ? s1_lo_q : old_min;
      new_max = (s1_hi_q > old_max) ? s1_hi_q : old_max;
    end
  end

  // memory write from stage 1, registered read for the new request
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      min_mem[s1_seq_q.ch[ADDR_W-1:0]] <= new_min;
      max_mem[s1_seq_q.ch[ADDR_W-1:0]] <= new_max;
    end
    if (accept) begin
      rd_min_q <= min_mem[seq.ch[ADDR_W-1:0]];
      rd_max_q <= max_mem[seq.ch[ADDR_W-1:0]];
    end
  end

  // stage 1 payload, plus bypass of the word being written this cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_seq_q  <= seq;
      s1_lo_q   <= sample_i.sample_low;
      s1_hi_q   <= single_plane ? sample_i.sample_low : sample_i.sample_high;
      fwd_min_q <= new_min;
      fwd_max_q <= new_max;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_adv && (s1_seq_q.ch == seq.ch);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // result register: loaded only on the last step of a group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_seq_q.step_last) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_seq_q.step_last) begin
      out_ch_q   <= s1_seq_q.ch;
      out_min_q  <= new_min;
      out_max_q  <= new_max;
      out_last_q <= s1_seq_q.ch_last;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.channel    = out_ch_q;
  assign result_o.min_value  = out_min_q;
  assign result_o.max_value  = out_max_q;
  assign result_o.group_last = out_last_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import mmd_pkg::*;

  typedef struct {
    sample_t lo;
    sample_t hi;
  } sample_pair_t;

  typedef struct {
    chan_t   channel;
    sample_t min_value;
    sample_t max_value;
    logic    group_last;
  } minmax_pair_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = '0;
  cfg_data_t            cfg_data_i = '0;

  // request side and result side, driven from local variables
  logic    smp_valid = 1'b0;
  sample_t smp_lo    = '0;
  sample_t smp_hi    = '0;
  logic    res_ready = 1'b0;

  mmd_sample_if smp ();
  mmd_result_if res ();

  assign smp.valid       = smp_valid;
  assign smp.sample_low  = smp_lo;
  assign smp.sample_high = smp_hi;
  assign res.ready       = res_ready;

  multichannel_minmax_decimator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (smp),
    .result_o   (res),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // tracking copy of the block: config, counters and per-channel envelope
  // --------------------------------------------------------------------------
  logic [NCH_W-1:0]  cfg_nch    = NCH_W'(1);
  logic [FAC_W-1:0]  cfg_fac    = FAC_W'(4);
  logic              cfg_single = 1'b1;

  chan_t             trk_ch   = '0;
  logic [STEP_W-1:0] trk_step = '0;
  sample_t           trk_min [MAX_CHANNELS];
  sample_t           trk_max [MAX_CHANNELS];

  sample_pair_t      sample_q [$];   // requests waiting for the driver
  minmax_pair_t      pair_q [$];     // min/max pairs the block still owes

  int unsigned pushed_cnt = 0;
  int unsigned taken_cnt  = 0;
  int unsigned fails      = 0;

  // idle behavior, set per phase
  bit src_idle = 1'b1;
  bit snk_idle = 1'b1;
  bit flood_on = 1'b0;
  logic choke  = 1'b0;

  // channel count 0 behaves as 1, anything past the memory depth as full depth
  function automatic int unsigned eff_channels(int unsigned nch);
    if (nch == 0) return 1;
    if (nch > MAX_CHANNELS) return MAX_CHANNELS;
    return nch;
  endfunction

  // factor 0 behaves as 1, anything past the step counter range saturates
  function automatic int unsigned eff_factor(int unsigned fac);
    if (fac == 0) return 1;
    if (fac > FACTOR_LIMIT) return FACTOR_LIMIT;
    return fac;
  endfunction

  // fold one accepted request into the running min/max of its channel
  function automatic void fold_sample(sample_t lo, sample_t hi_in);
    int unsigned  nch;
    int unsigned  fac;
    sample_t      hi;
    sample_t      mn;
    sample_t      mx;
    bit           ch_last;
    bit           step_last;
    minmax_pair_t pair;
    nch = eff_channels(cfg_nch);
    fac = eff_factor(cfg_fac);
    hi  = cfg_single ? lo : hi_in;
    // counters left past the end by a reconfiguration count as the end
    ch_last   = (32'(trk_ch) + 1 >= nch);
    step_last = (32'(trk_step) + 1 >= fac);
    if (trk_step == 0) begin
      mn = lo;
      mx = hi;
    end else begin
      mn = trk_min[trk_ch];
      mx = trk_max[trk_ch];
      if (lo < mn) mn = lo;
      if (hi > mx) mx = hi;
    end
    trk_min[trk_ch] = mn;
    trk_max[trk_ch] = mx;
    if (step_last) begin
      pair.channel    = trk_ch;
      pair.min_value  = mn;
      pair.max_value  = mx;
      pair.group_last = ch_last;
      pair_q.push_back(pair);
    end
    if (ch_last) begin
      trk_ch = '0;
      if (step_last) trk_step = '0;
      else trk_step = trk_step + 1'b1;
    end else begin
      trk_ch = trk_ch + 1'b1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // request driver
  // --------------------------------------------------------------------------
  function automatic int unsigned src_gap();
    int unsigned r;
    if (!src_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  int unsigned  gap_left = 0;
  sample_pair_t cur_req;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      smp_valid <= 1'b0;
    end else begin
      if (smp_valid && smp.ready) begin
        fold_sample(smp_lo, smp_hi);
        taken_cnt++;
      end
      if (!smp_valid || smp.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          smp_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          cur_req = sample_q.pop_front();
          smp_lo    <= cur_req.lo;
          smp_hi    <= cur_req.hi;
          smp_valid <= 1'b1;
          gap_left  = src_gap();
        end else begin
          smp_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor and checker
  // --------------------------------------------------------------------------
  function automatic int unsigned snk_stall();
    int unsigned r;
    if (!snk_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void check_pair();
    minmax_pair_t want;
    if (pair_q.size() == 0) begin
      $error("unexpected result: channel %0d min %0d max %0d",
             res.channel, res.min_value, res.max_value);
      fails++;
      return;
    end
    want = pair_q.pop_front();
    if (res.channel !== want.channel) begin
      $error("channel: expected %0d, got %0d", want.channel, res.channel);
      fails++;
    end
    if (res.min_value !== want.min_value) begin
      $error("min_value: expected %0d, got %0d", want.min_value, res.min_value);
      fails++;
    end
    if (res.max_value !== want.max_value) begin
      $error("max_value: expected %0d, got %0d", want.max_value, res.max_value);
      fails++;
    end
    if (res.group_last !== want.group_last) begin
      $error("group_last: expected %0b, got %0b", want.group_last, res.group_last);
      fails++;
    end
  endfunction

  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else begin
      if (res.valid && res_ready) check_pair();
      if (choke) begin
        res_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready  <= 1'b1;
        stall_left = snk_stall();
      end
    end
  end

  // long hold-off on the result side so the pipeline backs up into the input
  initial begin
    wait (flood_on);
    @(posedge clk_i);
    choke <= 1'b1;
    repeat (300) @(posedge clk_i);
    choke <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  function automatic void offer(sample_t lo, sample_t hi);
    sample_pair_t p;
    p.lo = lo;
    p.hi = hi;
    sample_q.push_back(p);
    pushed_cnt++;
  endfunction

  // extremes and small values show up often, the rest is full range
  function automatic sample_t pick_sample();
    int unsigned r;
    r = $urandom_range(0, 15);
    case (r)
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return '1;
      4, 5, 6, 7: return sample_t'($signed($urandom_range(0, 40)) - 20);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic write_reg(input reg_idx_e idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= cfg_data_t'(value);
    case (idx)
      REG_NUM_CHANNELS: cfg_nch    = value[NCH_W-1:0];
      REG_DECIM_FACTOR: cfg_fac    = value[FAC_W-1:0];
      REG_SINGLE_PLANE: cfg_single = value[0];
      default: ;
    endcase
  endtask

  task automatic set_mode(input int unsigned nch, input int unsigned fac, input bit single);
    write_reg(REG_NUM_CHANNELS, nch);
    write_reg(REG_DECIM_FACTOR, fac);
    write_reg(REG_SINGLE_PLANE, 32'(single));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // all requests taken, all pairs seen, then room for a request that owes nothing
  task automatic drain();
    while (taken_cnt != pushed_cnt || pair_q.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_random_phase(output int unsigned n_items);
    int unsigned r;
    int unsigned nch;
    int unsigned fac;
    int unsigned group;
    r = $urandom_range(0, 9);
    if (r < 6) nch = $urandom_range(1, 8);
    else if (r == 6) nch = MAX_CHANNELS;
    else if (r == 7) nch = $urandom_range(MAX_CHANNELS + 1, 127);
    else if (r == 8) nch = 0;
    else nch = $urandom_range(9, MAX_CHANNELS - 1);
    r = $urandom_range(0, 9);
    if (eff_channels(nch) > 8) fac = $urandom_range(0, 3);
    else if (r < 6) fac = $urandom_range(1, 6);
    else if (r < 8) fac = 0;
    else fac = $urandom_range(7, 40);
    set_mode(nch, fac, 1'($urandom_range(0, 1)));
    src_idle = ($urandom_range(0, 4) != 0);
    snk_idle = ($urandom_range(0, 4) != 0);
    group   = eff_channels(nch) * eff_factor(fac);
    n_items = group * ((group > 100) ? 1 : $urandom_range(1, 4));
    // sometimes stop inside a group so the next setting starts mid-stream
    if ($urandom_range(0, 3) == 0) n_items += $urandom_range(0, group - 1);
    for (int unsigned i = 0; i < n_items; i++) offer(pick_sample(), pick_sample());
    drain();
  endtask

  initial begin
    int unsigned done_items;
    int unsigned n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset setting: one channel, factor 4, raw samples; high input is junk
    offer(32'sh7FFF_FFFF, sample_t'($urandom));
    offer(32'sh8000_0000, sample_t'($urandom));
    offer('0, sample_t'($urandom));
    offer('1, sample_t'($urandom));
    offer('1, 32'sh7FFF_FFFF);
    offer(-32'sd2, 32'sh8000_0000);
    offer(32'sd1, '0);
    offer('0, '1);
    drain();

    // oversized channel count and factor zero: every channel written once
    set_mode(127, 0, 1'b0);
    for (int unsigned i = 0; i < MAX_CHANNELS; i++) offer(pick_sample(), pick_sample());
    drain();

    // channel count zero, pairs with low above high
    set_mode(0, 1, 1'b0);
    offer(32'sh7FFF_FFFF, 32'sh8000_0000);
    offer(32'sh8000_0000, 32'sh7FFF_FFFF);
    offer('0, '1);
    drain();

    // three channels, two steps, then stop inside a group
    set_mode(3, 2, 1'b0);
    offer(32'sd5, 32'sd10);
    offer(32'sh8000_0000, 32'sh8000_0000);
    offer('0, '0);
    offer(-32'sd3, 32'sd7);
    offer(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    offer('1, '0);
    for (int unsigned i = 0; i < 4; i++) offer(pick_sample(), pick_sample());
    drain();

    // shrink mid-stream: channel and step counters now sit past the end
    set_mode(1, 1, 1'b1);
    offer(32'sh8000_0000, 32'sh7FFF_FFFF);
    offer(32'sh7FFF_FFFF, 32'sh8000_0000);
    drain();

    // back up the result side while requests keep coming
    set_mode(4, 1, 1'b0);
    src_idle = 1'b1;
    snk_idle = 1'b1;
    flood_on = 1'b1;
    for (int unsigned i = 0; i < 400; i++) offer(pick_sample(), pick_sample());
    drain();
    done_items = pushed_cnt;

    while (done_items < 1200) begin
      run_random_phase(n);
      done_items += n;
    end

    // register maximum factor saturates to the full step range: no pair in a short run
    set_mode(1, 17'h1FFFF, 1'b0);
    src_idle = 1'b0;
    snk_idle = 1'b1;
    for (int unsigned i = 0; i < 40; i++) offer(pick_sample(), pick_sample());
    drain();

    // factor dropped below the step counter: each request ends its group
    set_mode(1, 1, 1'b0);
    offer(pick_sample(), pick_sample());
    offer(pick_sample(), pick_sample());
    drain();

    if (fails == 0) begin
      $display("PASS multichannel_minmax_decimator");
    end else begin
      $display("FAIL multichannel_minmax_decimator");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAIL multichannel_minmax_decimator");
    $finish;
  end

endmodule
